[rtl/lksm_pkg.sv]
// lksm_pkg: shared codes and defaults for the lamport k-slot mutex node
// no dependencies
`timescale 1ns / 1ps
package lksm_pkg;

	localparam int MAX_NODES_DEF  = 16;
	localparam int CLOCK_BITS_DEF = 32;

	// input modes
	localparam logic [2:0] MODE_LREQ = 3'd0;
	localparam logic [2:0] MODE_RREQ = 3'd1;
	localparam logic [2:0] MODE_RACK = 3'd2;
	localparam logic [2:0] MODE_RREL = 3'd3;
	localparam logic [2:0] MODE_LREL = 3'd4;

	// outgoing message kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REQ  = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;
	localparam logic [1:0] KIND_REL  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_OWN_ID     = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [1:0] REG_SLOT_COUNT = 2'd2;

	localparam logic [4:0] ACK_SAT   = 5'd31;
	localparam logic [4:0] AHEAD_SAT = 5'd31;

endpackage

[rtl/lamport_k_slot_mutex_node_core.sv]
// lamport_k_slot_mutex_node_core: one node of lamport-ordered mutual exclusion over k slots
// depends on lksm_pkg
`timescale 1ns / 1ps
// A beat is taken when start is high and busy is low; busy then stays high until the
// result is out. Each beat runs through the merge, increment, table-write and own-read
// states; when this node's own request is pending, it then scans the first
// min(node_count, MAX_NODES) entries of the request table, one per cycle on a single
// timestamp comparator, before the finish state. The shared saturating clock incrementer
// runs in the merge state and again, for a remote request only, in the increment state. The
// result is shown for exactly one cycle with done high and cannot be held off by the receiver.
module lamport_k_slot_mutex_node_core
	import lksm_pkg::*;
#(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int CLOCK_BITS = CLOCK_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  peer,
	input  logic [31:0] peer_clock,
	output logic        done,
	output logic [1:0]  send_kind,
	output logic [3:0]  send_dest,
	output logic [31:0] send_clock,
	output logic        may_enter,
	output logic [4:0]  ahead_count
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int LW = $clog2(MAX_NODES + 1);
	localparam int CB = CLOCK_BITS;
	localparam logic [63:0] CLK_MAX64 = (64'd1 << CLOCK_BITS) - 64'd1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MRG  = 3'd1;
	localparam logic [2:0] ST_INC  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_OWN  = 3'd4;
	localparam logic [2:0] ST_MINE = 3'd5;
	localparam logic [2:0] ST_SCAN = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]    st_q;
	logic [3:0]    own_id_q;
	logic [4:0]    node_count_q;
	logic [4:0]    slot_count_q;
	logic [CB-1:0] clk_q;
	logic [4:0]    acks_q;
	logic [MAX_NODES-1:0] vld_q;

	logic [2:0]    mode_q;
	logic [3:0]    peer_q;
	logic [CB-1:0] pc_q;
	logic [CB-1:0] mine_q;
	logic [IW:0]   idx_q;
	logic [IW:0]   tag_q;
	logic [4:0]    ahead_q;

	logic [CB-1:0] mem [MAX_NODES];
	logic [CB-1:0] rd_q;

	logic          done_q;
	logic [1:0]    kind_q;
	logic [3:0]    dest_q;
	logic [31:0]   sclk_q;
	logic          enter_q;
	logic [4:0]    ahead_out_q;

	logic [LW-1:0] lim_w;
	logic          own_in_w, peer_in_w, own_act_w;
	logic [IW-1:0] own_idx_w, peer_idx_w, ra_w, wa_w;
	logic          we_w;
	logic [CB-1:0] wd_w;
	logic [CB-1:0] pc_sat_w, op_w, inc_w;
	logic          recv_w;
	logic          hit_w;
	logic          last_w;
	logic [4:0]    need_w;
	logic [31:0]   sclk_w;
	logic          enter_w;

	assign lim_w      = (32'(node_count_q) < 32'(MAX_NODES)) ? LW'(node_count_q) : LW'(MAX_NODES);
	assign own_in_w   = 32'(own_id_q) < 32'(lim_w);
	assign peer_in_w  = (32'(peer_q) < 32'(lim_w)) && (peer_q != own_id_q);
	assign own_idx_w  = IW'(own_id_q);
	assign peer_idx_w = IW'(peer_q);
	assign own_act_w  = own_in_w && vld_q[own_idx_w];

	assign pc_sat_w = (64'(peer_clock) > CLK_MAX64) ? {CB{1'b1}} : CB'(peer_clock);

	// shared saturating incrementer
	assign recv_w = (mode_q == MODE_RREQ) || (mode_q == MODE_RACK) || (mode_q == MODE_RREL);
	assign op_w   = ((st_q == ST_MRG) && recv_w && (pc_q > clk_q)) ? pc_q : clk_q;
	assign inc_w  = (op_w == {CB{1'b1}}) ? op_w : op_w + CB'(1);

	// table port
	assign we_w = (st_q == ST_WR) &&
		(((mode_q == MODE_LREQ) && own_in_w) || ((mode_q == MODE_RREQ) && peer_in_w));
	assign wa_w = (mode_q == MODE_LREQ) ? own_idx_w : peer_idx_w;
	assign wd_w = (mode_q == MODE_LREQ) ? clk_q : pc_q;
	assign ra_w = (st_q == ST_OWN) ? own_idx_w : idx_q[IW-1:0];

	// one comparator over the table
	assign hit_w = (32'(tag_q) < 32'(lim_w)) && (32'(tag_q) != 32'(own_id_q)) &&
		vld_q[tag_q[IW-1:0]] &&
		((rd_q < mine_q) || ((rd_q == mine_q) && (32'(tag_q) < 32'(own_id_q))));
	assign last_w = (32'(tag_q) + 32'd1) >= 32'(lim_w);

	assign need_w  = (node_count_q != 5'd0) ? node_count_q - 5'd1 : 5'd0;
	assign enter_w = own_act_w && (acks_q >= need_w) && (ahead_q < slot_count_q);
	assign sclk_w  = (64'(clk_q) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(clk_q);

	always_ff @(posedge clk) begin
		if (we_w) begin
			mem[wa_w] <= wd_w;
		end
		rd_q <= mem[ra_w];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= 4'd0;
			node_count_q <= 5'd16;
			slot_count_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_ID:     own_id_q     <= cfg_wdata[3:0];
				REG_NODE_COUNT: node_count_q <= cfg_wdata;
				REG_SLOT_COUNT: slot_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			clk_q   <= '0;
			acks_q  <= 5'd0;
			vld_q   <= '0;
			idx_q   <= '0;
			tag_q   <= '0;
			ahead_q <= 5'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q    <= ST_MRG;
						idx_q   <= '0;
						ahead_q <= 5'd0;
					end
				end
				ST_MRG: begin
					if (mode_q <= MODE_LREL) begin
						clk_q <= inc_w;
					end
					st_q <= ST_INC;
				end
				ST_INC: begin
					if (mode_q == MODE_RREQ) begin
						clk_q <= inc_w;
					end
					st_q <= ST_WR;
				end
				ST_WR: begin
					unique case (mode_q)
						MODE_LREQ: begin
							acks_q <= 5'd0;
							if (own_in_w) vld_q[own_idx_w] <= 1'b1;
						end
						MODE_RREQ: if (peer_in_w) vld_q[peer_idx_w] <= 1'b1;
						MODE_RACK: if (acks_q != ACK_SAT) acks_q <= acks_q + 5'd1;
						MODE_RREL: if (peer_in_w) vld_q[peer_idx_w] <= 1'b0;
						MODE_LREL: if (own_in_w) vld_q[own_idx_w] <= 1'b0;
						default: ;
					endcase
					st_q <= ST_OWN;
				end
				ST_OWN: begin
					st_q <= own_act_w ? ST_MINE : ST_FIN;
				end
				ST_MINE: begin
					tag_q <= idx_q;
					idx_q <= idx_q + (IW+1)'(1);
					st_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit_w && (ahead_q != AHEAD_SAT)) begin
						ahead_q <= ahead_q + 5'd1;
					end
					tag_q <= idx_q;
					idx_q <= idx_q + (IW+1)'(1);
					if (last_w) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// beat payload and result registers
	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE) && start) begin
			mode_q <= mode;
			peer_q <= peer;
			pc_q   <= pc_sat_w;
		end
		if (st_q == ST_MINE) begin
			mine_q <= rd_q;
		end
		if (st_q == ST_FIN) begin
			enter_q     <= enter_w;
			ahead_out_q <= ahead_q;
			dest_q      <= 4'd0;
			sclk_q      <= 32'd0;
			priority case (mode_q)
				MODE_LREQ: begin
					kind_q <= KIND_REQ;
					sclk_q <= sclk_w;
				end
				MODE_RREQ: begin
					kind_q <= KIND_ACK;
					dest_q <= peer_q;
					sclk_q <= sclk_w;
				end
				MODE_LREL: begin
					kind_q <= KIND_REL;
					sclk_q <= sclk_w;
				end
				default: kind_q <= KIND_NONE;
			endcase
		end
	end

	assign busy        = (st_q != ST_IDLE);
	assign done        = done_q;
	assign send_kind   = kind_q;
	assign send_dest   = dest_q;
	assign send_clock  = sclk_q;
	assign may_enter   = enter_q;
	assign ahead_count = ahead_out_q;

endmodule

[rtl/lksm_chk.sv]
// lksm_chk: port-level checks for the lamport k-slot mutex node, bound to the top level
// depends on lksm_pkg and lamport_k_slot_mutex_node_core
`timescale 1ns / 1ps
module lksm_chk
	import lksm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  send_kind,
	input logic [3:0]  send_dest,
	input logic [31:0] send_clock
);

	// a taken beat always makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("beat taken without busy");

	// the result strobe comes exactly as busy drops
	a_done_fell: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("done without end of busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without result");

	// no message means no clock and no destination
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (send_kind == KIND_NONE)) |-> ((send_clock == 32'd0) && (send_dest == 4'd0)))
		else $error("payload on empty message");

	// a sent message always carries a clock past zero
	a_sent_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (send_kind != KIND_NONE)) |-> (send_clock != 32'd0))
		else $error("message with zero clock");

endmodule

bind lamport_k_slot_mutex_node_core lksm_chk u_lksm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.send_kind   (send_kind),
	.send_dest   (send_dest),
	.send_clock  (send_clock)
);
